@@ sv/rdq_pkg.sv @@
// Package: shared constants and operation codes for the ring deque.
package rdq_pkg;

    localparam int DEPTH      = 16;
    localparam int NODE_WIDTH = 64;
    localparam int NODE_IO_W  = 64;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int KIND_W     = 3;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_OVERWRITE = 3'd0,
        K_PUSH_TAIL      = 3'd1,
        K_PUSH_HEAD      = 3'd2,
        K_REPLACE_ALL    = 3'd3,
        K_PUSH_IF_EMPTY  = 3'd4,
        K_POP_HEAD       = 3'd5,
        K_CLEAR          = 3'd6
    } t_kind;

endpackage

@@ sv/rdq_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered read data.
module rdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ring_deque_multi_mode_push.sv @@
// Top level: ring-buffer deque of node words with several push modes and head pop.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per
//   transaction: i_kind selects push overwrite, push tail, push head,
//   replace all, push if empty, pop head or clear; i_in_node is the node word.
//   Output channel (o_out_valid / i_out_stall) returns exactly one result
//   transaction per operation, in order: o_ok, o_out_node (popped node, else
//   zero) and o_fill (entries held after the operation).
//   An accepted operation passes through stage 1 and then the output
//   register. Throughput: one operation per cycle while the receiver does
//   not stall. Head index and fill count live in registers and are updated
//   at accept, so the next operation sees them at once; each operation
//   makes at most one access to the node RAM (a write for pushes, a read
//   for pop), and pop data arrives from the RAM's read register in stage 1.
//   Reset (synchronous, active low) empties the deque and drops any results
//   in flight; the node RAM is not cleared, since no entry is read before
//   it was written.
//   When the receiver stalls, the result holds in the output register, the
//   pop stage holds behind it, and o_in_stall rises once both are occupied.
module ring_deque_multi_mode_push
    import rdq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [NODE_IO_W-1:0]  i_in_node,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_ok,
    output logic [NODE_IO_W-1:0]  o_out_node,
    output logic [CNT_W-1:0]      o_fill
);

    localparam int SUM_W = CNT_W + 1;

    // deque state
    logic [IDX_W-1:0]      r_head, n_head;
    logic [CNT_W-1:0]      r_count, n_count;

    // stage 1: operation issued to the RAM, waiting for read data
    logic                  r_s1_valid;
    logic                  r_s1_ok, n_ok;
    logic                  r_s1_pop, n_pop;
    logic [CNT_W-1:0]      r_s1_fill;

    // output register
    logic                  r_o_valid;
    logic                  r_o_ok;
    logic [NODE_IO_W-1:0]  r_o_node;
    logic [CNT_W-1:0]      r_o_fill;

    // RAM port
    logic                  we, re;
    logic [IDX_W-1:0]      waddr;
    logic [NODE_WIDTH-1:0] wdata, rdata;

    logic                  in_accept, s1_adv;
    logic                  full, empty;
    logic [SUM_W-1:0]      tail_sum;
    logic [IDX_W-1:0]      tail, head_inc, head_dec;
    t_kind                 kind;

    assign kind      = t_kind'(i_kind);
    assign s1_adv    = r_s1_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_accept = i_in_valid && !o_in_stall;

    assign full  = (r_count == CNT_W'(DEPTH));
    assign empty = (r_count == '0);

    // tail slot: head + count, wrapped once
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);
    assign head_inc = (r_head == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(r_head + 1'b1);
    assign head_dec = (r_head == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(r_head - 1'b1);

    assign wdata = i_in_node[NODE_WIDTH-1:0];

    // operation decode: next head, count and RAM access
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_ok    = 1'b0;
        n_pop   = 1'b0;
        we      = 1'b0;
        re      = 1'b0;
        waddr   = tail;
        if (in_accept) begin
            unique case (kind)
                K_PUSH_OVERWRITE: begin
                    we   = 1'b1;
                    n_ok = 1'b1;
                    // full: tail lands on the oldest slot, advance head
                    if (full) begin
                        n_head = head_inc;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                K_PUSH_TAIL: begin
                    if (!full) begin
                        we      = 1'b1;
                        n_count = r_count + 1'b1;
                        n_ok    = 1'b1;
                    end
                end
                K_PUSH_HEAD: begin
                    if (!full) begin
                        we      = 1'b1;
                        waddr   = head_dec;
                        n_head  = head_dec;
                        n_count = r_count + 1'b1;
                        n_ok    = 1'b1;
                    end
                end
                K_REPLACE_ALL: begin
                    we      = 1'b1;
                    waddr   = '0;
                    n_head  = '0;
                    n_count = CNT_W'(1);
                    n_ok    = 1'b1;
                end
                K_PUSH_IF_EMPTY: begin
                    if (empty) begin
                        we      = 1'b1;
                        waddr   = '0;
                        n_head  = '0;
                        n_count = CNT_W'(1);
                        n_ok    = 1'b1;
                    end
                end
                K_POP_HEAD: begin
                    if (!empty) begin
                        re      = 1'b1;
                        n_pop   = 1'b1;
                        n_head  = head_inc;
                        n_count = r_count - 1'b1;
                        n_ok    = 1'b1;
                    end
                end
                K_CLEAR: begin
                    n_head  = '0;
                    n_count = '0;
                    n_ok    = 1'b1;
                end
                default: begin
                    // unused code: no operation, refused
                end
            endcase
        end
    end

    rdq_ram #(
        .WIDTH (NODE_WIDTH),
        .DEPTH (DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    // deque state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload: stage 1 and output register
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ok   <= n_ok;
            r_s1_pop  <= n_pop;
            r_s1_fill <= n_count;
        end
        if (s1_adv) begin
            r_o_ok   <= r_s1_ok;
            r_o_fill <= r_s1_fill;
            r_o_node <= r_s1_pop ? NODE_IO_W'(rdata) : '0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_ok        = r_o_ok;
    assign o_out_node  = r_o_node;
    assign o_fill      = r_o_fill;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= IDX_W'(DEPTH - 1))
        else $error("head index beyond depth");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_ok |-> o_out_node == '0)
        else $error("refused result carries a node");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && kind == K_CLEAR |=> r_count == '0 && r_head == '0)
        else $error("clear left entries");

    a_pop_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && kind == K_POP_HEAD && empty |=> r_count == '0)
        else $error("pop on empty changed the count");

endmodule

@@ dv/ring_deque_multi_mode_push_tb.sv @@
// Testbench for the ring deque: directed and random operations checked against a shadow deque.
`timescale 1ns / 100ps

module ring_deque_multi_mode_push_tb;
    import rdq_pkg::*;

    // Kind code the block leaves unassigned: it must answer with a refusal
    // and leave the deque untouched.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    // Only the low NODE_WIDTH bits of a node word are stored.
    localparam logic [NODE_IO_W-1:0] NODE_KEEP = {NODE_IO_W{1'b1}} >> (NODE_IO_W - NODE_WIDTH);

    localparam int    RANDOM_OPS = 550;
    localparam int    DRAIN_CYCLES = 12;
    localparam time   RUN_LIMIT = 2_000_000ns;

    // Indexes into the calm-stretch counters, one per channel.
    localparam int SIDE_IN  = 0;
    localparam int SIDE_OUT = 1;

    typedef struct packed {
        logic                 ok;
        logic [NODE_IO_W-1:0] node;
        logic [CNT_W-1:0]     fill;
    } deque_result_t;

    // Shadow deque: mirrors head, fill count and node memory, and keeps
    // the results the block owes us, oldest first.
    class deque_shadow;
        logic [NODE_IO_W-1:0] slots [DEPTH];
        int unsigned          head_slot;
        int unsigned          held;
        deque_result_t        owed_results [$];
        int unsigned          errors;

        function new();
            head_slot = 0;
            held      = 0;
            errors    = 0;
            foreach (slots[i]) slots[i] = '0;
        endfunction

        // Apply one accepted operation and queue the result it must cause.
        function void apply_op(logic [KIND_W-1:0] kind, logic [NODE_IO_W-1:0] node);
            deque_result_t        res;
            logic [NODE_IO_W-1:0] word;
            word     = node & NODE_KEEP;
            res.ok   = 1'b0;
            res.node = '0;
            case (kind)
                K_PUSH_OVERWRITE: begin
                    slots[(head_slot + held) % DEPTH] = word;
                    if (held < DEPTH) held++;
                    else head_slot = (head_slot + 1) % DEPTH;
                    res.ok = 1'b1;
                end
                K_PUSH_TAIL: begin
                    if (held < DEPTH) begin
                        slots[(head_slot + held) % DEPTH] = word;
                        held++;
                        res.ok = 1'b1;
                    end
                end
                K_PUSH_HEAD: begin
                    if (held < DEPTH) begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        slots[head_slot] = word;
                        held++;
                        res.ok = 1'b1;
                    end
                end
                K_REPLACE_ALL: begin
                    slots[0]  = word;
                    head_slot = 0;
                    held      = 1;
                    res.ok    = 1'b1;
                end
                K_PUSH_IF_EMPTY: begin
                    if (held == 0) begin
                        slots[0]  = word;
                        head_slot = 0;
                        held      = 1;
                        res.ok    = 1'b1;
                    end
                end
                K_POP_HEAD: begin
                    if (held > 0) begin
                        res.node  = slots[head_slot];
                        head_slot = (head_slot + 1) % DEPTH;
                        held--;
                        res.ok    = 1'b1;
                    end
                end
                K_CLEAR: begin
                    head_slot = 0;
                    held      = 0;
                    res.ok    = 1'b1;
                end
                default: ;
            endcase
            res.fill = CNT_W'(held);
            owed_results.push_back(res);
        endfunction

        // Compare one delivered result with the oldest owed one.
        function void check_result(logic ok, logic [NODE_IO_W-1:0] node, logic [CNT_W-1:0] fill);
            deque_result_t want;
            if (owed_results.size() == 0) begin
                $error("unexpected result: ok %0b out_node %h fill %0d", ok, node, fill);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (ok !== want.ok) begin
                $error("ok: expected %0b, actual %0b", want.ok, ok);
                errors++;
            end
            if (node !== want.node) begin
                $error("out_node: expected %h, actual %h", want.node, node);
                errors++;
            end
            if (fill !== want.fill) begin
                $error("fill: expected %0d, actual %0d", want.fill, fill);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [KIND_W-1:0]    i_kind;
    logic [NODE_IO_W-1:0] i_in_node;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_ok;
    logic [NODE_IO_W-1:0] o_out_node;
    logic [CNT_W-1:0]     o_fill;

    deque_shadow shadow = new();
    int unsigned ops_sent;
    int unsigned calm_left [2];

    ring_deque_multi_mode_push u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_in_node   (i_in_node),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ok        (o_ok),
        .o_out_node  (o_out_node),
        .o_fill      (o_fill)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length for one channel: mostly none or short, now and then long,
    // with occasional calm stretches where the channel never idles at all.
    function automatic int unsigned pick_gap(input int side);
        int unsigned roll;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Node word: mostly random, with the corner patterns mixed in.
    function automatic logic [NODE_IO_W-1:0] pick_node();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return '0;
            1:       return '1;
            2:       return NODE_IO_W'(1) << $urandom_range(0, NODE_IO_W - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Present one transaction on the input channel and hold it until taken,
    // then hand it to the shadow deque.
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [NODE_IO_W-1:0] node);
        int unsigned gap;
        gap = pick_gap(SIDE_IN);
        repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_in_node  <= node;
        do @(posedge i_clk); while (o_in_stall);
        shadow.apply_op(kind, node);
        if (kind != KIND_UNUSED) ops_sent++;
    endtask

    // Walk every operation, the empty refusals, the unused code and the
    // extreme node words, including a push at the head of an empty deque.
    task automatic run_directed();
        send_op(K_POP_HEAD, '1);
        send_op(KIND_UNUSED, '1);
        send_op(K_PUSH_IF_EMPTY, '1);
        send_op(K_PUSH_IF_EMPTY, '0);
        send_op(K_POP_HEAD, '0);
        send_op(K_PUSH_HEAD, 64'hA5A5_5A5A_F00F_0FF0);
        send_op(K_PUSH_TAIL, '0);
        send_op(K_PUSH_OVERWRITE, 64'h8000_0000_0000_0001);
        send_op(K_PUSH_HEAD, 64'h7FFF_FFFF_FFFF_FFFE);
        send_op(K_POP_HEAD, '0);
        send_op(K_POP_HEAD, '1);
        send_op(K_POP_HEAD, '0);
        send_op(K_POP_HEAD, '0);
        send_op(K_POP_HEAD, '0);
        send_op(K_REPLACE_ALL, 64'h0123_4567_89AB_CDEF);
        send_op(K_PUSH_TAIL, 64'hFEDC_BA98_7654_3210);
        send_op(K_REPLACE_ALL, '1);
        send_op(K_POP_HEAD, '0);
        send_op(K_PUSH_OVERWRITE, '0);
        send_op(K_CLEAR, '1);
        send_op(K_POP_HEAD, '0);
        send_op(KIND_UNUSED, '0);
    endtask

    // Random part built from runs: fill runs that can reach full and
    // push past it, drain runs that can empty the deque and keep popping,
    // mixed runs over every code, and restarts through clear or replace.
    task automatic run_random();
        int unsigned          roll;
        int unsigned          len;
        logic [KIND_W-1:0]    kind;
        while (ops_sent < RANDOM_OPS) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                len = $urandom_range(10, 24);
                repeat (len) begin
                    roll = $urandom_range(0, 19);
                    if (roll < 8) kind = K_PUSH_OVERWRITE;
                    else if (roll < 13) kind = K_PUSH_TAIL;
                    else if (roll < 18) kind = K_PUSH_HEAD;
                    else kind = K_PUSH_IF_EMPTY;
                    send_op(kind, pick_node());
                end
            end else if (roll < 55) begin
                len = $urandom_range(8, 22);
                repeat (len) begin
                    kind = ($urandom_range(0, 7) == 0) ? K_PUSH_TAIL : K_POP_HEAD;
                    send_op(kind, pick_node());
                end
            end else if (roll < 90) begin
                len = $urandom_range(4, 12);
                repeat (len) begin
                    roll = $urandom_range(0, 30);
                    kind = (roll == 30) ? KIND_UNUSED : KIND_W'(roll % 7);
                    send_op(kind, pick_node());
                end
            end else begin
                kind = ($urandom_range(0, 1) == 0) ? K_CLEAR : K_REPLACE_ALL;
                send_op(kind, pick_node());
                send_op(K_PUSH_IF_EMPTY, pick_node());
            end
        end
    endtask

    // Result side: stall at random on the falling edge.
    initial begin
        int unsigned stall_len;
        i_out_stall = 1'b0;
        forever begin
            stall_len = pick_gap(SIDE_OUT);
            repeat ($urandom_range(1, 6)) @(negedge i_clk) i_out_stall <= 1'b0;
            repeat (stall_len) @(negedge i_clk) i_out_stall <= 1'b1;
        end
    end

    // Check each result transaction on the rising edge it is taken.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                shadow.check_result(o_ok, o_out_node, o_fill);
            end
        end
    end

    // Main sequence: reset, directed, random, then drain and report.
    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_kind     = K_PUSH_OVERWRITE;
        i_in_node  = '0;
        ops_sent   = 0;
        calm_left  = '{0, 0};
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        run_directed();
        ops_sent = 0;
        run_random();
        @(negedge i_clk) i_in_valid <= 1'b0;

        // Wait for every owed result, then give stragglers time to show.
        while (shadow.owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (shadow.errors == 0) begin
            $display("ring_deque_multi_mode_push test passed");
        end else begin
            $display("ring_deque_multi_mode_push test failed");
        end
        $finish;
    end

    // Watchdog: drop the run if it hangs.
    initial begin
        #RUN_LIMIT;
        $display("ring_deque_multi_mode_push test failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/rdq_pkg.sv
sv/rdq_ram.sv
sv/ring_deque_multi_mode_push.sv
dv/ring_deque_multi_mode_push_tb.sv
